[rtl/core/aligned_stack_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Aligned stack allocator assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_STACK_ALLOCATOR_ASSERT_SVH
`define ALIGNED_STACK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/asa_pkg.sv]
// ----------------------------------------------------------------------------
// Aligned stack allocator package
// Field widths, command and status codes, limits and shared struct types.
// ----------------------------------------------------------------------------
package asa_pkg;

   localparam int CMD_W   = 2;
   localparam int SIZE_W  = 25;
   localparam int ALIGN_W = 13;
   localparam int ADDR_W  = 32;
   localparam int STAT_W  = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_ALLOCATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RECORD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNWIND   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_ARG  = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_CAPACITY = 1'd1;

   localparam logic [ALIGN_W-1:0] MIN_ALIGN  = ALIGN_W'(8);
   localparam logic [ALIGN_W-1:0] MAX_ALIGN  = ALIGN_W'(4096);
   localparam logic [SIZE_W-1:0]  MAX_REGION = SIZE_W'(16777216);

   localparam logic [ADDR_W-1:0] BASE_RESET     = '0;
   localparam logic [SIZE_W-1:0] CAPACITY_RESET = SIZE_W'(16777216);

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [SIZE_W-1:0]  request_size;
      logic [ALIGN_W-1:0] request_alignment;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } stack_status_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stack_ctl_type;

   typedef struct packed {
      rsp_type           rsp;
      logic              used_load;
      logic [SIZE_W-1:0] used_next;
      stack_ctl_type     stk;
   } step_type;

endpackage

[rtl/core/asa_step_unit.sv]
// ----------------------------------------------------------------------------
// Allocator step unit
// Decodes one command against the current state and forms result and update.
// ----------------------------------------------------------------------------
module asa_step_unit (
   input  asa_pkg::req_type                req,
   input  logic [asa_pkg::ADDR_W-1:0]      region_base,
   input  logic [asa_pkg::SIZE_W-1:0]      region_capacity,
   input  logic [asa_pkg::SIZE_W-1:0]      used_bytes,
   input  asa_pkg::stack_status_type       stk_status,
   input  logic [asa_pkg::SIZE_W-1:0]      mark_top,
   output asa_pkg::step_type               step
);

   logic                          size_bad;
   logic                          align_bad;
   logic [asa_pkg::ALIGN_W-1:0]   align_mask;
   logic [asa_pkg::SIZE_W-1:0]    cap;
   logic [asa_pkg::ADDR_W:0]      cur;
   logic [asa_pkg::ALIGN_W-1:0]   pad;
   logic [asa_pkg::ADDR_W-1:0]    round_addr;
   logic [asa_pkg::SIZE_W:0]      total;
   logic [asa_pkg::SIZE_W-1:0]    room;
   logic                          no_space;

   assign align_mask = req.request_alignment - asa_pkg::ALIGN_W'(1);
   assign size_bad   = (req.request_size == '0) || (req.request_size > asa_pkg::MAX_REGION);
   assign align_bad  = (req.request_alignment == '0)
                    || ((req.request_alignment & align_mask) != '0)
                    || (req.request_alignment < asa_pkg::MIN_ALIGN)
                    || (req.request_alignment > asa_pkg::MAX_ALIGN);

   assign cap = (region_capacity > asa_pkg::MAX_REGION) ? asa_pkg::MAX_REGION
                                                        : region_capacity;
   assign cur = {1'b0, region_base} + {{(asa_pkg::ADDR_W + 1 - asa_pkg::SIZE_W){1'b0}},
                                       used_bytes};
   // Distance to the next boundary: the negated low bits, masked.
   assign pad = (~cur[asa_pkg::ALIGN_W-1:0] + asa_pkg::ALIGN_W'(1)) & align_mask;
   assign round_addr = cur[asa_pkg::ADDR_W-1:0]
                     + {{(asa_pkg::ADDR_W - asa_pkg::ALIGN_W){1'b0}}, pad};
   assign total = {1'b0, req.request_size}
                + {{(asa_pkg::SIZE_W + 1 - asa_pkg::ALIGN_W){1'b0}}, pad};
   assign room  = (used_bytes > cap) ? '0 : (cap - used_bytes);
   assign no_space = total > {1'b0, room};

   always_comb begin
      step                     = '0;
      step.rsp.status          = asa_pkg::ST_OK;
      step.used_next           = used_bytes;
      unique case (req.command)
         asa_pkg::CMD_ALLOCATE: begin
            if (size_bad || align_bad) begin
               step.rsp.status = asa_pkg::ST_BAD_ARG;
            end else if (no_space) begin
               step.rsp.status = asa_pkg::ST_NO_SPACE;
            end else begin
               step.rsp.granted_address = round_addr;
               step.used_load           = 1'b1;
               step.used_next           = used_bytes + total[asa_pkg::SIZE_W-1:0];
            end
         end
         asa_pkg::CMD_RECORD: begin
            if (stk_status.full) begin
               step.rsp.status = asa_pkg::ST_FULL;
            end else begin
               step.stk.push = 1'b1;
            end
         end
         asa_pkg::CMD_UNWIND: begin
            if (stk_status.empty) begin
               step.rsp.status = asa_pkg::ST_EMPTY;
            end else begin
               step.stk.pop   = 1'b1;
               step.used_load = 1'b1;
               step.used_next = mark_top;
            end
         end
         asa_pkg::CMD_CLEAR: begin
            step.stk.clear = 1'b1;
            step.used_load = 1'b1;
            step.used_next = '0;
         end
         default: begin
            step.rsp.status = asa_pkg::ST_BAD_ARG;
         end
      endcase
   end

endmodule

[rtl/core/asa_mark_stack.sv]
// ----------------------------------------------------------------------------
// Allocator mark stack
// Mark memory with a fill count and a registered top-of-stack entry.
// ----------------------------------------------------------------------------
module asa_mark_stack #(
   parameter int MARK_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  asa_pkg::stack_ctl_type         ctl,
   input  logic [asa_pkg::SIZE_W-1:0]     push_value,
   output asa_pkg::stack_status_type      status,
   output logic [asa_pkg::SIZE_W-1:0]     mark_top
);

   localparam int CNT_W = $clog2(MARK_DEPTH + 1);
   localparam int IDX_W = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;

   logic [asa_pkg::SIZE_W-1:0] mark_mem_ff [MARK_DEPTH];
   logic [asa_pkg::SIZE_W-1:0] top_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [CNT_W-1:0]           below_top;
   logic [IDX_W-1:0]           wr_idx;
   logic [IDX_W-1:0]           rd_idx;
   logic                       do_push;
   logic                       do_pop;

   assign do_push   = advance && ctl.push;
   assign do_pop    = advance && ctl.pop;
   assign below_top = count_ff - CNT_W'(2);
   assign wr_idx    = count_ff[IDX_W-1:0];
   assign rd_idx    = below_top[IDX_W-1:0];

   assign status.full  = (count_ff == CNT_W'(MARK_DEPTH));
   assign status.empty = (count_ff == '0);
   assign mark_top     = top_ff;

   always_comb begin
      count_in = count_ff;
      if (advance && ctl.clear) begin
         count_in = '0;
      end else if (do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Pushed value becomes the new top; a pop fetches the entry beneath it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mark_mem_ff[wr_idx] <= push_value;
         top_ff              <= push_value;
      end else if (do_pop && (count_ff > CNT_W'(1))) begin
         top_ff <= mark_mem_ff[rd_idx];
      end
   end

endmodule

[rtl/core/aligned_stack_allocator.sv]
// ----------------------------------------------------------------------------
// Aligned stack allocator
// Bump-pointer region allocator with a stack of saved marks.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : command transactions (allocate, record mark, unwind, clear).
//   rsp_*  : one result transaction per command: granted address and status.
//   csr_*  : register writes, index 0 region base, index 1 region capacity.
//            csr_ready is always high; write only while the block is idle.
// Path: an accepted transaction is held in the input register while the
//   step unit evaluates it, and its result is then loaded into the result
//   register, which drives rsp_valid and rsp_data.
// Throughput: one command per cycle unless rsp_stall blocks; the input and
//   result registers form a two-stage pipe, and the used-byte counter and
//   mark count update in the evaluation cycle, so the next command sees them.
// Stall: when rsp_stall holds a result, one more command may wait in the
//   input register; req_stall then rises until the result drains.
// Reset: clears both counts and returns the region registers to base zero
//   and full capacity; mark memory contents stay undefined and are only read
//   once a record has written them.
// ----------------------------------------------------------------------------
`include "aligned_stack_allocator_assert.svh"

module aligned_stack_allocator #(
   parameter int MARK_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  asa_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output asa_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [asa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [asa_pkg::ADDR_W-1:0]       csr_data
);

   // Configuration registers
   logic [asa_pkg::ADDR_W-1:0] base_ff;
   logic [asa_pkg::SIZE_W-1:0] capacity_ff;

   // Pipeline and allocator state
   logic                       in_vld_ff;
   asa_pkg::req_type           in_data_ff;
   logic                       out_vld_ff;
   asa_pkg::rsp_type           out_data_ff;
   logic [asa_pkg::SIZE_W-1:0] used_ff;
   logic [asa_pkg::SIZE_W-1:0] used_in;

   logic                       out_ready;
   logic                       advance;
   logic                       req_take;
   asa_pkg::step_type          step;
   asa_pkg::stack_status_type  stk_status;
   logic [asa_pkg::SIZE_W-1:0] mark_top;

   // Checker terms
   logic                       grant_ok;
   logic                       grant_aligned;
   logic                       used_in_range;

   // The result register frees when empty or when its transaction is taken.
   assign out_ready = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_ready;
   assign req_stall = in_vld_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= asa_pkg::BASE_RESET;
         capacity_ff <= asa_pkg::CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            asa_pkg::CSR_REGION_BASE: begin
               base_ff <= csr_data;
            end
            asa_pkg::CSR_REGION_CAPACITY: begin
               capacity_ff <= csr_data[asa_pkg::SIZE_W-1:0];
            end
            default: begin
               base_ff <= base_ff;
            end
         endcase
      end
   end

   // Input register: hold while the result side is blocked
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!in_vld_ff || advance) begin
         in_vld_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   asa_step_unit u_step (
      .req             (in_data_ff),
      .region_base     (base_ff),
      .region_capacity (capacity_ff),
      .used_bytes      (used_ff),
      .stk_status      (stk_status),
      .mark_top        (mark_top),
      .step            (step)
   );

   asa_mark_stack #(
      .MARK_DEPTH (MARK_DEPTH)
   ) u_marks (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ctl        (step.stk),
      .push_value (used_ff),
      .status     (stk_status),
      .mark_top   (mark_top)
   );

   // Used-byte counter: advance only when the command retires
   assign used_in = (advance && step.used_load) ? step.used_next : used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // Result register: load on retire, drop once taken downstream
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_ready) begin
         out_vld_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step.rsp;
      end
   end

   assign grant_ok      = advance && (in_data_ff.command == asa_pkg::CMD_ALLOCATE)
                       && (step.rsp.status == asa_pkg::ST_OK);
   assign grant_aligned = (step.rsp.granted_address[asa_pkg::ALIGN_W-1:0]
                          & (in_data_ff.request_alignment - asa_pkg::ALIGN_W'(1))) == '0;
   assign used_in_range = used_ff <= asa_pkg::MAX_REGION;

   `ASA_ASSERT_NEXT(a_retire_gives_result, clock, reset, advance, rsp_valid, "result missing")
   `ASA_ASSERT_SAME(a_grant_aligned, clock, reset, grant_ok, grant_aligned, "unaligned grant")
   `ASA_ASSERT_NEXT(a_used_bounded, clock, reset, advance, used_in_range, "used over limit")

endmodule
